// ===== rtl/core/cpt_pkg.sv =====
// ----------------------------------------------------------------------------
// cpt_pkg: shared types and constants for the closest point on triangle block
// Region codes of the result and the resolution of the weights.
// ----------------------------------------------------------------------------
package cpt_pkg;

  // Weights are unsigned fractions with this many bits (1.0 has its own flag).
  localparam int WEIGHT_BITS = 32;

  // Split point of the weight-by-vector multiply.
  localparam int SCALE_SPLIT = 16;

  // Split point of the wide cross-term multiply.
  localparam int CROSS_SPLIT = 32;

  // Region of the triangle that holds the nearest point.
  typedef enum logic [2:0] {
    RGN_VERT_A = 3'd0,
    RGN_VERT_B = 3'd1,
    RGN_VERT_C = 3'd2,
    RGN_EDGE_AB = 3'd3,
    RGN_EDGE_BC = 3'd4,
    RGN_EDGE_CA = 3'd5,
    RGN_INSIDE = 3'd6
  } region_t;

endpackage

// ===== rtl/core/closest_point_on_triangle.sv =====
// ----------------------------------------------------------------------------
// closest_point_on_triangle: nearest point of a triangle to a query point
// Fully pipelined; one query per cycle unless the output stalls, one result per query.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (s_axis) carries one query item: the point P and the
//   vertices A, B, C, each a signed fixed-point coordinate pair. The output
//   channel (m_axis) carries one result item per query: the nearest point
//   (saturated to the coordinate width) in tdata and its region code in tuser.
//   Throughput is one item per cycle when the output is not stalled. The
//   pipeline consists of the 32 restoring-division stages of the weight
//   dividers plus the dot product, cross term, selection and scaling stages
//   around them.
//   All stages move together: when an output item waits and tready is low,
//   the whole pipeline holds and s_axis_tready drops; nothing is lost or
//   repeated. A waiting output item blocks the input even while earlier
//   stages hold bubbles.
//   Reset clears every valid bit; items in flight are dropped and no state
//   other than the pipeline contents exists.
// ----------------------------------------------------------------------------
module closest_point_on_triangle #(
  parameter int COORD_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // point_x, point_y, vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y
  input  logic [((8*COORD_BITS+7)/8)*8-1:0]    s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // near_x, near_y
  output logic [((2*COORD_BITS+7)/8)*8-1:0]    m_axis_tdata,
  // region
  output cpt_pkg::region_t                     m_axis_tuser
);
  import cpt_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int DS = (CB > 30) ? CB - 30 : 0;
  localparam int VCW = CB + 1;
  localparam int FW = VCW - DS;
  localparam int PW = 2 * FW;
  localparam int DW = PW + 1;
  localparam int HW = DW - CROSS_SPLIT;
  localparam int VW = 2 * DW + 1;
  localparam int NW = VW + 2;
  localparam int WB = WEIGHT_BITS;
  localparam int SHW = VCW - SCALE_SPLIT;
  localparam int OUT_W = ((2 * CB + 7) / 8) * 8;
  localparam int NSTG = 13 + WB;
  localparam int DIV_IN = 10;

  typedef struct packed {
    logic signed [CB-1:0]  ax;
    logic signed [CB-1:0]  ay;
    logic signed [CB-1:0]  bx;
    logic signed [CB-1:0]  by;
    logic signed [CB-1:0]  cx;
    logic signed [CB-1:0]  cy;
    logic signed [VCW-1:0] abx;
    logic signed [VCW-1:0] aby;
    logic signed [VCW-1:0] acx;
    logic signed [VCW-1:0] acy;
    logic signed [VCW-1:0] cbx;
    logic signed [VCW-1:0] cby;
  } geo_t;

  typedef struct packed {
    logic signed [CB-1:0]  base_x;
    logic signed [CB-1:0]  base_y;
    logic signed [VCW-1:0] v1x;
    logic signed [VCW-1:0] v1y;
    logic signed [VCW-1:0] v2x;
    logic signed [VCW-1:0] v2y;
    region_t               rgn;
  } tail_t;

  // Pairs of dot products that form the six cross products.
  localparam int XA [6] = '{0, 2, 4, 0, 2, 4};
  localparam int XB [6] = '{3, 1, 1, 5, 5, 3};

  logic            adv;
  logic [NSTG:1]   vld;

  // The pipeline advances unless a finished item waits at the output.
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[NSTG];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-1:1], s_axis_tvalid};
    end
  end

  // Stage 1: register the coordinates.
  logic signed [CB-1:0] s1_c [0:7];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 8; i++) begin
        s1_c[i] <= s_axis_tdata[i*CB +: CB];
      end
    end
  end

  // Stage 2: exact edge and point vectors.
  geo_t                  s2_geo;
  logic signed [VCW-1:0] s2_pv [0:5];

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_geo.ax  <= s1_c[2];
      s2_geo.ay  <= s1_c[3];
      s2_geo.bx  <= s1_c[4];
      s2_geo.by  <= s1_c[5];
      s2_geo.cx  <= s1_c[6];
      s2_geo.cy  <= s1_c[7];
      s2_geo.abx <= VCW'(s1_c[4]) - VCW'(s1_c[2]);
      s2_geo.aby <= VCW'(s1_c[5]) - VCW'(s1_c[3]);
      s2_geo.acx <= VCW'(s1_c[6]) - VCW'(s1_c[2]);
      s2_geo.acy <= VCW'(s1_c[7]) - VCW'(s1_c[3]);
      s2_geo.cbx <= VCW'(s1_c[6]) - VCW'(s1_c[4]);
      s2_geo.cby <= VCW'(s1_c[7]) - VCW'(s1_c[5]);
      for (int i = 0; i < 3; i++) begin
        s2_pv[2*i]   <= VCW'(s1_c[0]) - VCW'(s1_c[2+2*i]);
        s2_pv[2*i+1] <= VCW'(s1_c[1]) - VCW'(s1_c[3+2*i]);
      end
    end
  end

  // Stage 3: floored vectors and the twelve dot-product terms.
  logic signed [FW-1:0] f_ab [0:1];
  logic signed [FW-1:0] f_ac [0:1];
  logic signed [FW-1:0] f_p  [0:5];
  geo_t                 s3_geo;
  logic signed [PW-1:0] s3_t [0:11];

  always_comb begin
    f_ab[0] = FW'(s2_geo.abx >>> DS);
    f_ab[1] = FW'(s2_geo.aby >>> DS);
    f_ac[0] = FW'(s2_geo.acx >>> DS);
    f_ac[1] = FW'(s2_geo.acy >>> DS);
    for (int i = 0; i < 6; i++) begin
      f_p[i] = FW'(s2_pv[i] >>> DS);
    end
  end

  // Term order: d1 = ab.pa, d2 = ac.pa, d3 = ab.pb, d4 = ac.pb, d5 = ab.pc, d6 = ac.pc.
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_geo <= s2_geo;
      for (int i = 0; i < 3; i++) begin
        s3_t[4*i]   <= f_ab[0] * f_p[2*i];
        s3_t[4*i+1] <= f_ab[1] * f_p[2*i+1];
        s3_t[4*i+2] <= f_ac[0] * f_p[2*i];
        s3_t[4*i+3] <= f_ac[1] * f_p[2*i+1];
      end
    end
  end

  // Stage 4: dot products d1 to d6.
  geo_t                 s4_geo;
  logic signed [DW-1:0] s4_d [0:5];

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_geo <= s3_geo;
      for (int i = 0; i < 6; i++) begin
        s4_d[i] <= DW'(s3_t[2*i]) + DW'(s3_t[2*i+1]);
      end
    end
  end

  // Stage 5: partial products of the six cross products.
  geo_t                              s5_geo;
  logic signed [DW-1:0]              s5_d  [0:5];
  logic [2*CROSS_SPLIT-1:0]          s5_ll [0:5];
  logic signed [CROSS_SPLIT+HW:0]    s5_lh [0:5];
  logic signed [CROSS_SPLIT+HW:0]    s5_hl [0:5];
  logic signed [2*HW-1:0]            s5_hh [0:5];

  for (genvar j = 0; j < 6; j++) begin : g_xpart
    logic [CROSS_SPLIT-1:0] xl, yl;
    logic signed [HW-1:0]   xh, yh;

    assign xl = s4_d[XA[j]][CROSS_SPLIT-1:0];
    assign yl = s4_d[XB[j]][CROSS_SPLIT-1:0];
    assign xh = s4_d[XA[j]][DW-1:CROSS_SPLIT];
    assign yh = s4_d[XB[j]][DW-1:CROSS_SPLIT];

    always_ff @(posedge clk) begin
      if (adv) begin
        s5_ll[j] <= xl * yl;
        s5_lh[j] <= $signed({1'b0, xl}) * yh;
        s5_hl[j] <= xh * $signed({1'b0, yl});
        s5_hh[j] <= xh * yh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_geo <= s4_geo;
      s5_d   <= s4_d;
    end
  end

  // Stage 6: the cross products d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4.
  geo_t                 s6_geo;
  logic signed [DW-1:0] s6_d [0:5];
  logic signed [VW-1:0] s6_m [0:5];

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_geo <= s5_geo;
      s6_d   <= s5_d;
      for (int j = 0; j < 6; j++) begin
        s6_m[j] <= (VW'(s5_hh[j]) <<< (2 * CROSS_SPLIT))
                 + (VW'(s5_lh[j]) <<< CROSS_SPLIT)
                 + (VW'(s5_hl[j]) <<< CROSS_SPLIT)
                 + VW'({1'b0, s5_ll[j]});
      end
    end
  end

  // Stage 7: barycentric cross terms va, vb, vc.
  geo_t                 s7_geo;
  logic signed [DW-1:0] s7_d [0:5];
  logic signed [VW-1:0] s7_va, s7_vb, s7_vc;

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_geo <= s6_geo;
      s7_d   <= s6_d;
      s7_vc  <= s6_m[0] - s6_m[1];
      s7_vb  <= s6_m[2] - s6_m[3];
      s7_va  <= s6_m[4] - s6_m[5];
    end
  end

  // Stage 8: region tests in priority order and choice of the weight operands.
  logic signed [DW:0]   e43, e56;
  logic signed [NW-1:0] sum_v;
  logic signed [NW-1:0] sel_n1, sel_d1, sel_n2, sel_d2;
  tail_t                sel_tl;
  logic signed [NW-1:0] s8_n1, s8_d1, s8_n2, s8_d2;
  tail_t                s8_tl;

  always_comb begin
    e43   = (DW+1)'(s7_d[3]) - (DW+1)'(s7_d[2]);
    e56   = (DW+1)'(s7_d[4]) - (DW+1)'(s7_d[5]);
    sum_v = NW'(s7_va) + NW'(s7_vb) + NW'(s7_vc);
    // Default: interior, weights vb/S on AB and vc/S on AC from A.
    sel_n1 = NW'(s7_vb);
    sel_d1 = sum_v;
    sel_n2 = NW'(s7_vc);
    sel_d2 = sum_v;
    sel_tl.base_x = s7_geo.ax;
    sel_tl.base_y = s7_geo.ay;
    sel_tl.v1x    = s7_geo.abx;
    sel_tl.v1y    = s7_geo.aby;
    sel_tl.v2x    = s7_geo.acx;
    sel_tl.v2y    = s7_geo.acy;
    sel_tl.rgn    = RGN_INSIDE;
    if (s7_d[0] <= 0 && s7_d[1] <= 0) begin
      sel_tl.rgn = RGN_VERT_A;
    end else if (s7_d[2] >= 0 && s7_d[3] <= s7_d[2]) begin
      sel_tl.rgn    = RGN_VERT_B;
      sel_tl.base_x = s7_geo.bx;
      sel_tl.base_y = s7_geo.by;
    end else if (s7_vc <= 0 && s7_d[0] >= 0 && s7_d[2] <= 0) begin
      sel_tl.rgn = RGN_EDGE_AB;
    end else if (s7_d[5] >= 0 && s7_d[4] <= s7_d[5]) begin
      sel_tl.rgn    = RGN_VERT_C;
      sel_tl.base_x = s7_geo.cx;
      sel_tl.base_y = s7_geo.cy;
    end else if (s7_vb <= 0 && s7_d[1] >= 0 && s7_d[5] <= 0) begin
      sel_tl.rgn = RGN_EDGE_CA;
      sel_tl.v1x = s7_geo.acx;
      sel_tl.v1y = s7_geo.acy;
    end else if (s7_va <= 0 && e43 >= 0 && e56 >= 0) begin
      sel_tl.rgn    = RGN_EDGE_BC;
      sel_tl.base_x = s7_geo.bx;
      sel_tl.base_y = s7_geo.by;
      sel_tl.v1x    = s7_geo.cbx;
      sel_tl.v1y    = s7_geo.cby;
    end
    // Operands per region; a zero divisor forces the weight to zero.
    case (sel_tl.rgn)
      RGN_VERT_A, RGN_VERT_B, RGN_VERT_C: begin
        sel_n1 = '0;
        sel_d1 = '0;
        sel_n2 = '0;
        sel_d2 = '0;
      end
      RGN_EDGE_AB: begin
        sel_n1 = NW'(s7_d[0]);
        sel_d1 = NW'(s7_d[0]) - NW'(s7_d[2]);
        sel_n2 = '0;
        sel_d2 = '0;
      end
      RGN_EDGE_CA: begin
        sel_n1 = NW'(s7_d[1]);
        sel_d1 = NW'(s7_d[1]) - NW'(s7_d[5]);
        sel_n2 = '0;
        sel_d2 = '0;
      end
      RGN_EDGE_BC: begin
        sel_n1 = NW'(e43);
        sel_d1 = NW'(e43) + NW'(e56);
        sel_n2 = '0;
        sel_d2 = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_n1 <= sel_n1;
      s8_d1 <= sel_d1;
      s8_n2 <= sel_n2;
      s8_d2 <= sel_d2;
      s8_tl <= sel_tl;
    end
  end

  // Stage 9: magnitudes, and the zero-weight cases (zero or sign mismatch).
  logic [NW-1:0] s9_mn1, s9_md1, s9_mn2, s9_md2;
  logic          s9_z1, s9_z2;
  tail_t         s9_tl;

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_tl  <= s8_tl;
      s9_mn1 <= s8_n1[NW-1] ? NW'(-s8_n1) : NW'(s8_n1);
      s9_md1 <= s8_d1[NW-1] ? NW'(-s8_d1) : NW'(s8_d1);
      s9_mn2 <= s8_n2[NW-1] ? NW'(-s8_n2) : NW'(s8_n2);
      s9_md2 <= s8_d2[NW-1] ? NW'(-s8_d2) : NW'(s8_d2);
      s9_z1  <= (s8_n1 == '0) || (s8_d1 == '0) || (s8_n1[NW-1] != s8_d1[NW-1]);
      s9_z2  <= (s8_n2 == '0) || (s8_d2 == '0) || (s8_n2[NW-1] != s8_d2[NW-1]);
    end
  end

  // Divider pipeline; index 0 is stage 10, index k is stage 10 + k.
  logic [NW-1:0] dr1 [0:WB];
  logic [NW-1:0] dd1 [0:WB];
  logic [NW-1:0] dr2 [0:WB];
  logic [NW-1:0] dd2 [0:WB];
  logic [WB-1:0] dq1 [0:WB];
  logic [WB-1:0] dq2 [0:WB];
  logic          one1 [0:WB];
  logic          one2 [0:WB];
  tail_t         dtl [0:WB];

  // Stage 10: a quotient of one or more saturates; a forced zero divides 0 by 1.
  logic ge1, ge2;

  assign ge1 = !s9_z1 && (s9_mn1 >= s9_md1);
  assign ge2 = !s9_z2 && (s9_mn2 >= s9_md2);

  always_ff @(posedge clk) begin
    if (adv) begin
      dtl[0]  <= s9_tl;
      one1[0] <= ge1;
      one2[0] <= ge2;
      dr1[0]  <= (s9_z1 || ge1) ? '0 : s9_mn1;
      dr2[0]  <= (s9_z2 || ge2) ? '0 : s9_mn2;
      dd1[0]  <= s9_z1 ? NW'(1) : s9_md1;
      dd2[0]  <= s9_z2 ? NW'(1) : s9_md2;
      dq1[0]  <= '0;
      dq2[0]  <= '0;
    end
  end

  // Restoring division, one quotient bit per stage for each divider.
  for (genvar k = 0; k < WB; k++) begin : g_div
    logic [NW:0] sh1, sh2, sb1, sb2;

    assign sh1 = {dr1[k], 1'b0};
    assign sh2 = {dr2[k], 1'b0};
    assign sb1 = sh1 - {1'b0, dd1[k]};
    assign sb2 = sh2 - {1'b0, dd2[k]};

    always_ff @(posedge clk) begin
      if (adv) begin
        dtl[k+1]  <= dtl[k];
        one1[k+1] <= one1[k];
        one2[k+1] <= one2[k];
        dd1[k+1]  <= dd1[k];
        dd2[k+1]  <= dd2[k];
        dr1[k+1]  <= sb1[NW] ? sh1[NW-1:0] : sb1[NW-1:0];
        dr2[k+1]  <= sb2[NW] ? sh2[NW-1:0] : sb2[NW-1:0];
        dq1[k+1]  <= {dq1[k][WB-2:0], !sb1[NW]};
        dq2[k+1]  <= {dq2[k][WB-2:0], !sb2[NW]};
      end
    end
  end

  // Stage 43: partial products of the four vector components by their weights.
  logic signed [VCW-1:0]           sc_vec [0:3];
  logic [WB-1:0]                   sc_q   [0:3];
  logic                            sc_one [0:3];
  logic [SCALE_SPLIT+WB-1:0]       s43_pl [0:3];
  logic signed [SHW+WB:0]          s43_ph [0:3];
  logic                            s43_one [0:3];
  tail_t                           s43_tl;

  assign sc_vec[0] = dtl[WB].v1x;
  assign sc_vec[1] = dtl[WB].v1y;
  assign sc_vec[2] = dtl[WB].v2x;
  assign sc_vec[3] = dtl[WB].v2y;
  assign sc_q[0]   = dq1[WB];
  assign sc_q[1]   = dq1[WB];
  assign sc_q[2]   = dq2[WB];
  assign sc_q[3]   = dq2[WB];
  assign sc_one[0] = one1[WB];
  assign sc_one[1] = one1[WB];
  assign sc_one[2] = one2[WB];
  assign sc_one[3] = one2[WB];

  for (genvar j = 0; j < 4; j++) begin : g_scale
    logic [SCALE_SPLIT-1:0] vl;
    logic signed [SHW-1:0]  vh;

    assign vl = sc_vec[j][SCALE_SPLIT-1:0];
    assign vh = sc_vec[j][VCW-1:SCALE_SPLIT];

    always_ff @(posedge clk) begin
      if (adv) begin
        s43_pl[j]  <= vl * sc_q[j];
        s43_ph[j]  <= vh * $signed({1'b0, sc_q[j]});
        s43_one[j] <= sc_one[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s43_tl <= dtl[WB];
    end
  end

  // Stage 44: floor(vector * weight / 2^32), or the vector itself at weight one.
  logic [VCW+WB-1:0]     sc_prod [0:3];
  logic signed [VCW-1:0] s44_s   [0:3];
  tail_t                 s44_tl;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      sc_prod[j] = ((VCW+WB)'(s43_ph[j]) <<< SCALE_SPLIT)
                 + (VCW+WB)'({1'b0, s43_pl[j]});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s44_tl   <= s43_tl;
      s44_s[0] <= s43_one[0] ? s43_tl.v1x : sc_prod[0][VCW+WB-1:WB];
      s44_s[1] <= s43_one[1] ? s43_tl.v1y : sc_prod[1][VCW+WB-1:WB];
      s44_s[2] <= s43_one[2] ? s43_tl.v2x : sc_prod[2][VCW+WB-1:WB];
      s44_s[3] <= s43_one[3] ? s43_tl.v2y : sc_prod[3][VCW+WB-1:WB];
    end
  end

  // Stage 45: base plus both scaled vectors, saturated; this is the output register.
  logic signed [CB+2:0] sum_x, sum_y;
  logic [CB-1:0]        sat_x, sat_y;
  logic [CB-1:0]        out_x, out_y;
  region_t              out_rgn;

  always_comb begin
    sum_x = (CB+3)'(s44_tl.base_x) + (CB+3)'(s44_s[0]) + (CB+3)'(s44_s[2]);
    sum_y = (CB+3)'(s44_tl.base_y) + (CB+3)'(s44_s[1]) + (CB+3)'(s44_s[3]);
    if (sum_x[CB+2:CB-1] == '0 || sum_x[CB+2:CB-1] == '1) begin
      sat_x = sum_x[CB-1:0];
    end else begin
      sat_x = sum_x[CB+2] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
    end
    if (sum_y[CB+2:CB-1] == '0 || sum_y[CB+2:CB-1] == '1) begin
      sat_y = sum_y[CB-1:0];
    end else begin
      sat_y = sum_y[CB+2] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x   <= sat_x;
      out_y   <= sat_y;
      out_rgn <= s44_tl.rgn;
    end
  end

  assign m_axis_tdata = OUT_W'({out_y, out_x});
  assign m_axis_tuser = out_rgn;

  // Vertex regions enter the dividers with both weights forced to zero.
  a_vertex_zero: assert property (@(posedge clk) disable iff (rst)
    vld[DIV_IN] && (dtl[0].rgn == RGN_VERT_A || dtl[0].rgn == RGN_VERT_B ||
                    dtl[0].rgn == RGN_VERT_C)
    |-> dr1[0] == '0 && !one1[0] && dr2[0] == '0 && !one2[0])
    else $error("vertex region with a nonzero weight");

  // Only the interior uses the second weight.
  a_second_weight: assert property (@(posedge clk) disable iff (rst)
    vld[DIV_IN] && dtl[0].rgn != RGN_INSIDE |-> dr2[0] == '0 && !one2[0])
    else $error("second weight active outside the interior");

  // Both interior weights divide by the magnitude of the same sum.
  a_shared_den: assert property (@(posedge clk) disable iff (rst)
    vld[DIV_IN-1] && s9_tl.rgn == RGN_INSIDE |-> s9_md1 == s9_md2)
    else $error("interior weights with different divisors");

  // The final partial remainder of each divider stays below its divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    vld[DIV_IN + WB] |-> dr1[WB] < dd1[WB] && dr2[WB] < dd2[WB])
    else $error("divider remainder out of range");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule
